[rtl/pagc_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, constants, register indexes and control types of the peak-envelope AGC.
package pagc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ENV_W      = 17;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 14;
  localparam int LEVEL_W    = 16;
  localparam int RC_W       = 21;
  localparam int RISE_W     = 10;
  localparam int Q20_SHIFT  = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam int DIV_STEPS  = GAIN_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [ENV_W-1:0]   ENV_RESET    = ENV_W'(8258);
  localparam logic [GAIN_W-1:0]  GAIN_RESET   = GAIN_W'(16384);
  localparam logic [LEVEL_W-1:0] TARGET_RESET = LEVEL_W'(8258);
  localparam logic [GAIN_W-1:0]  MAXG_RESET   = GAIN_W'(14746);
  localparam logic [RC_W-1:0]    RC_RESET     = RC_W'(210);
  localparam logic [ENV_W-1:0]   ENV_FLOOR    = ENV_W'(66);
  localparam logic [RISE_W-1:0]  GAIN_RISE    = RISE_W'(524);
  localparam logic [RC_W-1:0]    ONE_Q20      = RC_W'(1 << Q20_SHIFT);
  localparam logic [GAIN_W-1:0]  GAIN_MAX     = {GAIN_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] FULL_SCALE  = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AGC_ENABLE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = CFG_IDX_W'(3);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ENV_MUL,
    OP_ENV_UPD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_GAIN_MUL,
    OP_GAIN_UPD,
    OP_OUT_MUL,
    OP_OUT_SCALE,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic agc_on;
  } status_t;

endpackage

[rtl/pagc_dp.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, envelope, serial divider, gain smoothing, output scaling.
module pagc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pagc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pagc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic signed [pagc_pkg::SAMPLE_W-1:0] in_sample_in,
  input  pagc_pkg::cmd_t                    cmd,
  output pagc_pkg::status_t                 status,
  output logic signed [pagc_pkg::SAMPLE_W-1:0] out_sample_out
);

  localparam int SW     = pagc_pkg::SAMPLE_W;
  localparam int EW     = pagc_pkg::ENV_W;
  localparam int GW     = pagc_pkg::GAIN_W;
  localparam int NUM_W  = pagc_pkg::LEVEL_W + pagc_pkg::GAIN_FRAC;
  localparam int EPR_W  = pagc_pkg::RC_W + EW;
  localparam int GPR_W  = pagc_pkg::RISE_W + GW;
  localparam int P1_W   = SW + GW;
  localparam int P2_W   = P1_W + SW - 1;
  localparam int OSHIFT = SW - 1 + pagc_pkg::GAIN_FRAC;

  // configuration
  logic                            agc_enable_r;
  logic [pagc_pkg::LEVEL_W-1:0]    target_r;
  logic [GW-1:0]                   maxg_r;
  logic [pagc_pkg::RC_W-1:0]       rc_r;

  // item and state
  logic [SW-1:0]    sample_r;
  logic [SW-1:0]    mag_r;
  logic             neg_r;
  logic             bypass_r;
  logic [EW-1:0]    env_r;
  logic [GW-1:0]    gain_r;
  logic [EW-1:0]    a_r;
  logic [EW-1:0]    d_r;
  logic             grow_r;
  logic [EPR_W-1:0] eprod_r;
  logic [EW-1:0]    den_r;
  logic [EW-1:0]    rem_r;
  logic [GW-1:0]    qbits_r;
  logic             sat_r;
  logic [GW-1:0]    ideal_r;
  logic             drop_r;
  logic [GPR_W-1:0] gprod_r;
  logic [P1_W-1:0]  p1_r;
  logic [P2_W-1:0]  p2_r;
  logic [SW-1:0]    out_r;

  // combinational terms
  logic [SW-1:0]    raw;
  logic [SW-1:0]    mag_in;
  logic [SW+EW-1:0] a_wide;
  logic [EW-1:0]    a_val;
  logic [EW-1:0]    d_val;
  logic [pagc_pkg::RC_W-1:0] rc_sat;
  logic [EPR_W-1:0] esum;
  logic [EW:0]      dec;
  logic [EW:0]      dec_lim;
  logic [EW-1:0]    den_val;
  logic [NUM_W-1:0] num;
  logic [EW+GW-1:0] num_ext;
  logic [EW+GW-1:0] den_shift;
  logic [EW:0]      trial;
  logic [EW:0]      trial_diff;
  logic             trial_ge;
  logic [GW-1:0]    quot;
  logic [GW-1:0]    ideal_val;
  logic [GW-1:0]    gdiff;
  logic [GPR_W:0]   gsum;
  logic [GW:0]      inc;
  logic [GW:0]      gain_sum;
  logic [P2_W-1:0]  res_wide;
  logic [SW-1:0]    res;
  logic [SW-1:0]    out_val;

  assign raw    = in_sample_in;
  assign mag_in = raw[SW-1] ? (~raw + SW'(1)) : raw;

  assign a_wide = {mag_r, {EW{1'b0}}} >> SW;
  assign a_val  = a_wide[EW-1:0];
  assign d_val  = env_r - a_val;
  assign rc_sat = (rc_r > pagc_pkg::ONE_Q20) ? pagc_pkg::ONE_Q20 : rc_r;

  // round half up, never past the gap itself
  assign esum    = eprod_r + EPR_W'(1 << (pagc_pkg::Q20_SHIFT - 1));
  assign dec     = esum[EPR_W-1:pagc_pkg::Q20_SHIFT];
  assign dec_lim = (dec > {1'b0, d_r}) ? {1'b0, d_r} : dec;

  assign den_val   = (env_r < pagc_pkg::ENV_FLOOR) ? pagc_pkg::ENV_FLOOR : env_r;
  assign num       = {target_r, {pagc_pkg::GAIN_FRAC{1'b0}}};
  assign num_ext   = (EW+GW)'(num);
  assign den_shift = {den_val, {GW{1'b0}}};

  assign trial      = {rem_r, qbits_r[GW-1]};
  assign trial_diff = trial - {1'b0, den_r};
  assign trial_ge   = (trial >= {1'b0, den_r});

  assign quot      = sat_r ? pagc_pkg::GAIN_MAX : qbits_r;
  assign ideal_val = (quot > maxg_r) ? maxg_r : quot;
  assign gdiff     = ideal_val - gain_r;

  assign gsum     = (GPR_W+1)'(gprod_r) + (GPR_W+1)'(1 << (pagc_pkg::Q20_SHIFT - 1));
  assign inc      = (GW+1)'(gsum >> pagc_pkg::Q20_SHIFT);
  assign gain_sum = {1'b0, gain_r} + inc;

  assign res_wide = p2_r >> OSHIFT;
  assign res      = (res_wide > P2_W'(pagc_pkg::FULL_SCALE)) ? pagc_pkg::FULL_SCALE
                                                             : res_wide[SW-1:0];
  assign out_val  = bypass_r ? sample_r : (neg_r ? (~res + SW'(1)) : res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agc_enable_r <= 1'b1;
      target_r     <= pagc_pkg::TARGET_RESET;
      maxg_r       <= pagc_pkg::MAXG_RESET;
      rc_r         <= pagc_pkg::RC_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pagc_pkg::REG_AGC_ENABLE:    agc_enable_r <= cfg_wdata[0];
        pagc_pkg::REG_TARGET_LEVEL:  target_r     <= cfg_wdata[pagc_pkg::LEVEL_W-1:0];
        pagc_pkg::REG_MAX_GAIN:      maxg_r       <= cfg_wdata[GW-1:0];
        pagc_pkg::REG_RELEASE_COEFF: rc_r         <= cfg_wdata[pagc_pkg::RC_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r  <= pagc_pkg::ENV_RESET;
      gain_r <= pagc_pkg::GAIN_RESET;
    end else begin
      unique case (cmd.op)
        pagc_pkg::OP_ENV_UPD:  env_r <= grow_r ? a_r : (env_r - dec_lim[EW-1:0]);
        pagc_pkg::OP_GAIN_UPD: begin
          if (drop_r) begin
            gain_r <= ideal_r;
          end else begin
            gain_r <= gain_sum[GW] ? pagc_pkg::GAIN_MAX : gain_sum[GW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pagc_pkg::OP_LOAD: begin
        sample_r <= raw;
        mag_r    <= mag_in;
        neg_r    <= raw[SW-1];
        bypass_r <= !agc_enable_r;
      end
      pagc_pkg::OP_ENV_MUL: begin
        a_r     <= a_val;
        d_r     <= d_val;
        grow_r  <= (a_val > env_r);
        eprod_r <= EPR_W'(rc_sat) * EPR_W'(d_val);
      end
      pagc_pkg::OP_DIV_INIT: begin
        den_r   <= den_val;
        sat_r   <= (num_ext >= den_shift);
        rem_r   <= EW'(num >> GW);
        qbits_r <= num[GW-1:0];
      end
      pagc_pkg::OP_DIV_STEP: begin
        rem_r   <= trial_ge ? trial_diff[EW-1:0] : trial[EW-1:0];
        qbits_r <= {qbits_r[GW-2:0], trial_ge};
      end
      pagc_pkg::OP_GAIN_MUL: begin
        ideal_r <= ideal_val;
        drop_r  <= (ideal_val < gain_r);
        gprod_r <= GPR_W'(pagc_pkg::GAIN_RISE) * GPR_W'(gdiff);
      end
      pagc_pkg::OP_OUT_MUL:   p1_r  <= P1_W'(mag_r) * P1_W'(gain_r);
      pagc_pkg::OP_OUT_SCALE: p2_r  <= P2_W'(p1_r) * P2_W'(pagc_pkg::FULL_SCALE);
      pagc_pkg::OP_OUT_LOAD:  out_r <= out_val;
      default: ;
    endcase
  end

  assign status.agc_on  = agc_enable_r;
  assign out_sample_out = out_r;

endmodule

[rtl/pagc_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences one request through the datapath and owns both handshakes.
module pagc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pagc_pkg::status_t  status,
  output pagc_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENV_MUL,
    S_ENV_UPD,
    S_DIV_INIT,
    S_DIV,
    S_GAIN_MUL,
    S_GAIN_UPD,
    S_OUT_MUL,
    S_OUT_SCALE,
    S_OUT_FIN
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pagc_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = pagc_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = pagc_pkg::OP_LOAD;
          state_nxt = status.agc_on ? S_ENV_MUL : S_OUT_FIN;
        end
      end
      S_ENV_MUL: begin
        cmd.op    = pagc_pkg::OP_ENV_MUL;
        state_nxt = S_ENV_UPD;
      end
      S_ENV_UPD: begin
        cmd.op    = pagc_pkg::OP_ENV_UPD;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op    = pagc_pkg::OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = pagc_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == pagc_pkg::DIV_CNT_W'(pagc_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_GAIN_MUL;
        end
      end
      S_GAIN_MUL: begin
        cmd.op    = pagc_pkg::OP_GAIN_MUL;
        state_nxt = S_GAIN_UPD;
      end
      S_GAIN_UPD: begin
        cmd.op    = pagc_pkg::OP_GAIN_UPD;
        state_nxt = S_OUT_MUL;
      end
      S_OUT_MUL: begin
        cmd.op    = pagc_pkg::OP_OUT_MUL;
        state_nxt = S_OUT_SCALE;
      end
      S_OUT_SCALE: begin
        cmd.op    = pagc_pkg::OP_OUT_SCALE;
        state_nxt = S_OUT_FIN;
      end
      S_OUT_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.op        = pagc_pkg::OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/peak_envelope_audio_agc.sv]
`timescale 1ns / 1ps
// Peak-envelope AGC top level: one request in, one gain-adjusted sample out.
// With gain control on, a request passes envelope update, the 16-step serial gain divider,
// gain smoothing and output scaling; a new request is taken only after the last result is loaded.
// With gain control off the sample passes through unscaled, also one request at a time.
// A waiting result sits in the output register while the next request is processed.
// Synchronous active-low reset: envelope 8258, gain 16384, registers to their defaults.
module peak_envelope_audio_agc (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [pagc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pagc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pagc_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pagc_pkg::SAMPLE_W-1:0] out_sample_out
);

  pagc_pkg::cmd_t    cmd;
  pagc_pkg::status_t status;

  pagc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pagc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_sample_in   (in_sample_in),
    .cmd            (cmd),
    .status         (status),
    .out_sample_out (out_sample_out)
  );

  // a taken request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in progress");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == pagc_pkg::OP_OUT_LOAD |-> (!out_valid || out_ready))
    else $error("output register loaded over a pending result");

  a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == pagc_pkg::OP_OUT_LOAD |=> out_valid)
    else $error("result loaded but not presented");

  // datapath only loads a request while idle and handshaking
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == pagc_pkg::OP_LOAD |-> (in_valid && in_ready))
    else $error("sample loaded without an accepted request");

endmodule

[test/agc_sample_checker.sv]
`timescale 1ns / 1ps
// Checker for the peak-envelope AGC: tracks registers, predicts each sample and compares.
module agc_sample_checker
  import pagc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] out_sample_out,
  output int                         samples_in_flight,
  output int                         mismatch_count
);

  logic                 agc_on;
  logic [LEVEL_W-1:0]   target_lvl;
  logic [GAIN_W-1:0]    gain_ceiling;
  logic [RC_W-1:0]      release_wt;
  logic [ENV_W-1:0]     envelope_q;
  logic [GAIN_W-1:0]    gain_q;

  logic signed [SAMPLE_W-1:0] gained_samples_q[$];
  int                         errors;

  // Advance the envelope and gain by one sample and return the scaled sample.
  function automatic logic [SAMPLE_W-1:0] apply_agc(input logic [SAMPLE_W-1:0] raw);
    logic        neg;
    logic [63:0] mag, lvl, rc, gap, dec, env_div, ideal, inc, res;
    neg = raw[SAMPLE_W-1];
    mag = neg ? (64'd1 << SAMPLE_W) - 64'(raw) : 64'(raw);
    if (!agc_on) return raw;

    lvl = (mag << 17) >> SAMPLE_W;
    if (lvl > 64'(envelope_q)) begin
      envelope_q = ENV_W'(lvl);
    end else begin
      rc  = (release_wt > ONE_Q20) ? 64'(ONE_Q20) : 64'(release_wt);
      gap = 64'(envelope_q) - lvl;
      dec = (rc * gap + (64'd1 << (Q20_SHIFT - 1))) >> Q20_SHIFT;
      if (dec > gap) dec = gap;
      envelope_q = ENV_W'(64'(envelope_q) - dec);
    end

    env_div = (envelope_q < ENV_FLOOR) ? 64'(ENV_FLOOR) : 64'(envelope_q);
    ideal   = (64'(target_lvl) << GAIN_FRAC) / env_div;
    if (ideal > 64'(GAIN_MAX)) ideal = 64'(GAIN_MAX);
    if (ideal > 64'(gain_ceiling)) ideal = 64'(gain_ceiling);

    // drop at once, rise slowly
    if (ideal < 64'(gain_q)) begin
      gain_q = GAIN_W'(ideal);
    end else begin
      inc = (64'(GAIN_RISE) * (ideal - 64'(gain_q)) + (64'd1 << (Q20_SHIFT - 1))) >> Q20_SHIFT;
      inc = 64'(gain_q) + inc;
      gain_q = (inc > 64'(GAIN_MAX)) ? GAIN_MAX : GAIN_W'(inc);
    end

    res = (mag * 64'(gain_q) * 64'(FULL_SCALE)) >> (SAMPLE_W - 1 + GAIN_FRAC);
    if (res > 64'(FULL_SCALE)) res = 64'(FULL_SCALE);
    return neg ? SAMPLE_W'((64'd1 << SAMPLE_W) - res) : SAMPLE_W'(res);
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      agc_on       = 1'b1;
      target_lvl   = TARGET_RESET;
      gain_ceiling = MAXG_RESET;
      release_wt   = RC_RESET;
      envelope_q   = ENV_RESET;
      gain_q       = GAIN_RESET;
      gained_samples_q.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_AGC_ENABLE:    agc_on       = cfg_wdata[0];
          REG_TARGET_LEVEL:  target_lvl   = cfg_wdata[LEVEL_W-1:0];
          REG_MAX_GAIN:      gain_ceiling = cfg_wdata[GAIN_W-1:0];
          REG_RELEASE_COEFF: release_wt   = cfg_wdata[RC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) gained_samples_q.push_back(apply_agc(in_sample_in));
      if (out_valid && out_ready) begin
        if (gained_samples_q.size() == 0) begin
          $display("%0t: unexpected sample_out: expected none, actual %0d",
                   $time, out_sample_out);
          errors++;
        end else begin
          want = gained_samples_q.pop_front();
          if (out_sample_out !== want) begin
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, want, out_sample_out);
            errors++;
          end
        end
      end
    end
    samples_in_flight <= gained_samples_q.size();
    mismatch_count    <= errors;
  end

endmodule

[test/peak_envelope_audio_agc_test.sv]
`timescale 1ns / 1ps
// Testbench top for the peak-envelope AGC: clock, reset, register setup, stimulus and verdict.
module peak_envelope_audio_agc_test;
  import pagc_pkg::*;

  localparam int NUM_PHASES     = 14;
  localparam int PHASE_ITEMS    = 125;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LONG_HOLD      = 600;
  // longest stretch with no handshake on either side before the run is failed
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic [1:0] {SEG_FULL, SEG_QUIET, SEG_MID, SEG_CORNER} seg_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  int                         samples_in_flight;
  int                         mismatch_count;

  int tx_gap_pct;
  int rx_stall_pct;
  bit hold_off_req;

  peak_envelope_audio_agc u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out)
  );

  agc_sample_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_in      (in_sample_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .samples_in_flight (samples_in_flight),
    .mismatch_count    (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for every result, then let the datapath go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (samples_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Junk in the upper bits must be dropped by the block.
  task automatic program_agc(input logic en, input logic [LEVEL_W-1:0] tgt,
                             input logic [GAIN_W-1:0] mg, input logic [RC_W-1:0] rc);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_AGC_ENABLE, {junk[CFG_DATA_W-1:1], en});
    write_reg(REG_TARGET_LEVEL, {junk[CFG_DATA_W-1:LEVEL_W], tgt});
    write_reg(REG_MAX_GAIN, {junk[CFG_DATA_W-1:GAIN_W], mg});
    write_reg(REG_RELEASE_COEFF, CFG_DATA_W'(rc));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] next_sample(input seg_t mode);
    int mag;
    case (mode)
      SEG_FULL:  return SAMPLE_W'($urandom);
      SEG_QUIET: mag = $urandom_range(0, 300);
      SEG_MID:   mag = $urandom_range(0, 6000);
      default: begin
        case ($urandom_range(0, 5))
          0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
          1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
          2:       return {1'b1, {(SAMPLE_W-2){1'b0}}, 1'b1};
          3:       return '0;
          4:       return '1;
          default: return SAMPLE_W'(1);
        endcase
      end
    endcase
    return $urandom_range(0, 1) ? SAMPLE_W'(mag) : SAMPLE_W'(-mag);
  endfunction

  // Receiver: random stall bursts plus one long hold-off on request.
  initial begin
    int stall_left;
    bit hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int          corner_vals[];
    int          bypass_vals[];
    logic        en;
    logic [15:0] tgt, mg;
    logic [20:0] rc;
    seg_t        seg;
    int          seg_left;

    corner_vals  = '{0, 32767, -32768, -32767, 1, -1, 16384, -16384, 0, 0};
    bypass_vals  = '{-32768, 32767, 23130, -1};
    tx_gap_pct   = 20;
    rx_stall_pct = 6;
    hold_off_req = 1'b0;
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= REG_AGC_ENABLE;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_sample_in <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: full scale, most negative code, then decay
    foreach (corner_vals[i]) send_sample(SAMPLE_W'(corner_vals[i]));
    settle();
    program_agc(1'b0, LEVEL_W'(8258), GAIN_W'(14746), RC_W'(210));
    foreach (bypass_vals[i]) send_sample(SAMPLE_W'(bypass_vals[i]));
    settle();
    // release above one, top target and gain
    program_agc(1'b1, '1, '1, '1);
    send_sample(SAMPLE_W'(100));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(-32768));
    send_sample(SAMPLE_W'(5));
    settle();
    program_agc(1'b1, '0, '0, '0);
    send_sample(SAMPLE_W'(1000));
    send_sample(SAMPLE_W'(-1000));
    settle();

    seg      = SEG_FULL;
    seg_left = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      en = ($urandom_range(0, 99) < 85);
      case ($urandom_range(0, 3))
        0:       tgt = '0;
        1:       tgt = '1;
        2:       tgt = 16'($urandom_range(2000, 20000));
        default: tgt = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       mg = '0;
        1:       mg = '1;
        2:       mg = 16'($urandom_range(8192, 32768));
        default: mg = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       rc = '0;
        1:       rc = ONE_Q20;
        2:       rc = '1;
        3:       rc = 21'($urandom_range(0, 4096));
        default: rc = 21'($urandom_range(0, 1 << Q20_SHIFT));
      endcase
      program_agc(en, tgt, mg, rc);

      if (ph >= NUM_PHASES - 2 || ph == 6) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct   = 20;
        rx_stall_pct = 6;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 40) hold_off_req = 1'b1;
        if (seg_left == 0) begin
          seg      = seg_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        send_sample(next_sample(seg));
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
